### src/sfa_pkg.sv
package sfa_pkg;

   localparam int FRAC_BITS = 16;

   // Smallest raw distance that is not below 1e-6
   localparam logic [31:0] NEAR_LIMIT =
      32'(((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000);

   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 31;

   localparam logic [1:0] FUNC_SEEK   = 2'd0;
   localparam logic [1:0] FUNC_FLEE   = 2'd1;
   localparam logic [1:0] FUNC_ARRIVE = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [1:0] CSR_MAX_SPEED   = 2'd0;
   localparam logic [1:0] CSR_MAX_FORCE   = 2'd1;
   localparam logic [1:0] CSR_SLOW_RADIUS = 2'd2;

   localparam logic [30:0] MAX_SPEED_RESET   = 31'd65536;
   localparam logic [30:0] MAX_FORCE_RESET   = 31'd65536;
   localparam logic [30:0] SLOW_RADIUS_RESET = 31'd131072;

   typedef struct packed {
      logic               valid;
      logic [1:0]         func;
      logic               sx;
      logic               sy;
      logic [31:0]        ux;
      logic [31:0]        uy;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } side_a_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         func;
      logic               sx;
      logic               sy;
      logic [31:0]        ux;
      logic [31:0]        uy;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic [31:0]        span;
      logic               near;
      logic               arr;
   } side_b_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic               near;
      logic               sx;
      logic               sy;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } side_c_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic signed [33:0] fx;
      logic signed [33:0] fy;
   } side_d_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic               big;
      logic               sfx;
      logic               sfy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic [30:0]        ax;
      logic [30:0]        ay;
   } side_e_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic               clamp;
      logic               sfx;
      logic               sfy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic [30:0]        ax;
      logic [30:0]        ay;
   } side_f_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic               clamp;
      logic               sfx;
      logic               sfy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
   } side_g_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### src/sfa_req_if.sv
interface sfa_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;

   modport source (output valid, func, pos_x, pos_y, vel_x, vel_y, target_x, target_y,
                   input ready);
   modport sink (input valid, func, pos_x, pos_y, vel_x, vel_y, target_x, target_y,
                 output ready);
endinterface

### src/sfa_rsp_if.sv
interface sfa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;

   modport source (output valid, force_x, force_y, input ready);
   modport sink (input valid, force_x, force_y, output ready);
endinterface

### src/steering_force_seek_flee_arrive_unit.sv
// A request accepted on req passes through every stage below and shows its force on rsp from the output register.
// Throughput: one request per cycle; the pipeline advances whenever the output register
// is empty or being taken, so a stall holds every stage in place.
// Depth is set by the two 32-stage square roots and the three 31-stage divider rows.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module steering_force_seek_flee_arrive_unit (
   input  logic        clock,
   input  logic        reset,
   sfa_req_if.sink     req_bus,
   sfa_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   logic [30:0] max_speed_ff;
   logic [30:0] max_force_ff;
   logic [30:0] slow_radius_ff;

   logic en;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff   <= sfa_pkg::MAX_SPEED_RESET;
         max_force_ff   <= sfa_pkg::MAX_FORCE_RESET;
         slow_radius_ff <= sfa_pkg::SLOW_RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            sfa_pkg::CSR_MAX_SPEED:   max_speed_ff   <= csr_wdata;
            sfa_pkg::CSR_MAX_FORCE:   max_force_ff   <= csr_wdata;
            sfa_pkg::CSR_SLOW_RADIUS: slow_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- offset to target ----------------
   sfa_pkg::side_a_type a1_in, a1_ff;
   logic signed [32:0] dxw, dyw;
   logic signed [31:0] dx, dy;

   always_comb begin
      if (req_bus.func == sfa_pkg::FUNC_FLEE) begin
         dxw = {req_bus.pos_x[31], req_bus.pos_x} - {req_bus.target_x[31], req_bus.target_x};
         dyw = {req_bus.pos_y[31], req_bus.pos_y} - {req_bus.target_y[31], req_bus.target_y};
      end else begin
         dxw = {req_bus.target_x[31], req_bus.target_x} - {req_bus.pos_x[31], req_bus.pos_x};
         dyw = {req_bus.target_y[31], req_bus.target_y} - {req_bus.pos_y[31], req_bus.pos_y};
      end
      dx = sfa_pkg::sat32(dxw);
      dy = sfa_pkg::sat32(dyw);
      a1_in.valid = req_bus.valid;
      a1_in.func  = req_bus.func;
      a1_in.sx    = dx[31];
      a1_in.sy    = dy[31];
      a1_in.ux    = dx[31] ? 32'(-dx) : dx;
      a1_in.uy    = dy[31] ? 32'(-dy) : dy;
      a1_in.vx    = req_bus.vel_x;
      a1_in.vy    = req_bus.vel_y;
   end

   // ---------------- squared distance ----------------
   sfa_pkg::side_a_type a2_ff, a3_ff;
   logic [63:0] sqx_ff, sqy_ff, rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff <= '0;
         a2_ff <= '0;
         a3_ff <= '0;
      end else if (en) begin
         a1_ff <= a1_in;
         a2_ff <= a1_ff;
         a3_ff <= a2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= {32'b0, a1_ff.ux} * {32'b0, a1_ff.ux};
         sqy_ff <= {32'b0, a1_ff.uy} * {32'b0, a1_ff.uy};
         rad_ff <= sqx_ff + sqy_ff;
      end
   end

   logic [31:0] span;
   sfa_pkg::side_a_type line_a_ff [sfa_pkg::SQRT_STAGES];

   sfa_sqrt u_sqrt_dist (
      .clock    (clock),
      .en       (en),
      .radicand (rad_ff),
      .root     (span)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfa_pkg::SQRT_STAGES; i++) line_a_ff[i] <= '0;
      end else if (en) begin
         line_a_ff[0] <= a3_ff;
         for (int i = 1; i < sfa_pkg::SQRT_STAGES; i++) line_a_ff[i] <= line_a_ff[i-1];
      end
   end

   // ---------------- arrive speed ----------------
   sfa_pkg::side_a_type a_out;
   sfa_pkg::side_b_type b4_in, b4_ff;
   logic [62:0] spd_num_ff;

   assign a_out = line_a_ff[sfa_pkg::SQRT_STAGES-1];

   always_comb begin
      b4_in.valid = a_out.valid;
      b4_in.func  = a_out.func;
      b4_in.sx    = a_out.sx;
      b4_in.sy    = a_out.sy;
      b4_in.ux    = a_out.ux;
      b4_in.uy    = a_out.uy;
      b4_in.vx    = a_out.vx;
      b4_in.vy    = a_out.vy;
      b4_in.span  = span;
      b4_in.near  = span < sfa_pkg::NEAR_LIMIT;
      b4_in.arr   = (a_out.func == sfa_pkg::FUNC_ARRIVE) && (span < {1'b0, slow_radius_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b4_ff <= '0;
      end else if (en) begin
         b4_ff <= b4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spd_num_ff <= {32'b0, max_speed_ff} * {31'b0, span};
      end
   end

   logic [30:0] arr_speed;
   sfa_pkg::side_b_type line_b_ff [sfa_pkg::DIV_STAGES];

   sfa_div u_div_speed (
      .clock (clock),
      .en    (en),
      .num   (spd_num_ff),
      .den   ({1'b0, slow_radius_ff}),
      .quo   (arr_speed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfa_pkg::DIV_STAGES; i++) line_b_ff[i] <= '0;
      end else if (en) begin
         line_b_ff[0] <= b4_ff;
         for (int i = 1; i < sfa_pkg::DIV_STAGES; i++) line_b_ff[i] <= line_b_ff[i-1];
      end
   end

   // ---------------- desired velocity ----------------
   sfa_pkg::side_b_type b_out;
   sfa_pkg::side_c_type c5_in, c5_ff;
   logic [30:0] speed;
   logic [62:0] prx_ff, pry_ff;
   logic [31:0] dist_ff;

   assign b_out = line_b_ff[sfa_pkg::DIV_STAGES-1];
   assign speed = b_out.arr ? arr_speed : max_speed_ff;

   always_comb begin
      c5_in.valid = b_out.valid;
      c5_in.zero  = (b_out.func == sfa_pkg::FUNC_NONE)
                    || ((b_out.func == sfa_pkg::FUNC_FLEE) && b_out.near);
      c5_in.near  = b_out.near;
      c5_in.sx    = b_out.sx;
      c5_in.sy    = b_out.sy;
      c5_in.vx    = b_out.vx;
      c5_in.vy    = b_out.vy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c5_ff <= '0;
      end else if (en) begin
         c5_ff <= c5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prx_ff  <= {31'b0, b_out.ux} * {32'b0, speed};
         pry_ff  <= {31'b0, b_out.uy} * {32'b0, speed};
         dist_ff <= b_out.span;
      end
   end

   logic [30:0] desx_mag, desy_mag;
   sfa_pkg::side_c_type line_c_ff [sfa_pkg::DIV_STAGES];

   sfa_div u_div_desx (
      .clock (clock),
      .en    (en),
      .num   (prx_ff),
      .den   (dist_ff),
      .quo   (desx_mag)
   );

   sfa_div u_div_desy (
      .clock (clock),
      .en    (en),
      .num   (pry_ff),
      .den   (dist_ff),
      .quo   (desy_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfa_pkg::DIV_STAGES; i++) line_c_ff[i] <= '0;
      end else if (en) begin
         line_c_ff[0] <= c5_ff;
         for (int i = 1; i < sfa_pkg::DIV_STAGES; i++) line_c_ff[i] <= line_c_ff[i-1];
      end
   end

   // ---------------- raw force ----------------
   sfa_pkg::side_c_type c_out;
   sfa_pkg::side_d_type d6_in, d6_ff;
   logic signed [33:0] desx, desy;

   assign c_out = line_c_ff[sfa_pkg::DIV_STAGES-1];

   always_comb begin
      // Zero distance: desired velocity is zero
      if (c_out.near) begin
         desx = '0;
         desy = '0;
      end else begin
         desx = c_out.sx ? -$signed({3'b0, desx_mag}) : $signed({3'b0, desx_mag});
         desy = c_out.sy ? -$signed({3'b0, desy_mag}) : $signed({3'b0, desy_mag});
      end
      d6_in.valid = c_out.valid;
      d6_in.zero  = c_out.zero;
      d6_in.fx    = desx - {{2{c_out.vx[31]}}, c_out.vx};
      d6_in.fy    = desy - {{2{c_out.vy[31]}}, c_out.vy};
   end

   sfa_pkg::side_e_type e7_in, e7_ff, e8_ff;
   logic [33:0] magx, magy;

   always_comb begin
      magx = d6_ff.fx[33] ? 34'(-d6_ff.fx) : d6_ff.fx;
      magy = d6_ff.fy[33] ? 34'(-d6_ff.fy) : d6_ff.fy;
      e7_in.valid = d6_ff.valid;
      e7_in.zero  = d6_ff.zero;
      e7_in.big   = (magx[32:31] != 2'b00) || (magy[32:31] != 2'b00);
      e7_in.sfx   = d6_ff.fx[33];
      e7_in.sfy   = d6_ff.fy[33];
      e7_in.fx    = d6_ff.fx[31:0];
      e7_in.fy    = d6_ff.fy[31:0];
      // Halve both magnitudes when either overflows 31 bits
      e7_in.ax    = e7_in.big ? magx[31:1] : magx[30:0];
      e7_in.ay    = e7_in.big ? magy[31:1] : magy[30:0];
   end

   // ---------------- clamp test ----------------
   logic [61:0] axsq_ff, aysq_ff, mfsq_ff;
   sfa_pkg::side_f_type f9_in, f9_ff;
   logic [63:0] rad2_ff;

   always_comb begin
      f9_in.valid = e8_ff.valid;
      f9_in.zero  = e8_ff.zero;
      f9_in.clamp = e8_ff.big || (({1'b0, axsq_ff} + {1'b0, aysq_ff}) > {1'b0, mfsq_ff});
      f9_in.sfx   = e8_ff.sfx;
      f9_in.sfy   = e8_ff.sfy;
      f9_in.fx    = e8_ff.fx;
      f9_in.fy    = e8_ff.fy;
      f9_in.ax    = e8_ff.ax;
      f9_in.ay    = e8_ff.ay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d6_ff <= '0;
         e7_ff <= '0;
         e8_ff <= '0;
         f9_ff <= '0;
      end else if (en) begin
         d6_ff <= d6_in;
         e7_ff <= e7_in;
         e8_ff <= e7_ff;
         f9_ff <= f9_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axsq_ff <= {31'b0, e7_ff.ax} * {31'b0, e7_ff.ax};
         aysq_ff <= {31'b0, e7_ff.ay} * {31'b0, e7_ff.ay};
         mfsq_ff <= {31'b0, max_force_ff} * {31'b0, max_force_ff};
         rad2_ff <= {2'b0, axsq_ff} + {2'b0, aysq_ff};
      end
   end

   logic [31:0] len;
   sfa_pkg::side_f_type line_f_ff [sfa_pkg::SQRT_STAGES];

   sfa_sqrt u_sqrt_len (
      .clock    (clock),
      .en       (en),
      .radicand (rad2_ff),
      .root     (len)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfa_pkg::SQRT_STAGES; i++) line_f_ff[i] <= '0;
      end else if (en) begin
         line_f_ff[0] <= f9_ff;
         for (int i = 1; i < sfa_pkg::SQRT_STAGES; i++) line_f_ff[i] <= line_f_ff[i-1];
      end
   end

   // ---------------- length limit ----------------
   sfa_pkg::side_f_type f_out;
   sfa_pkg::side_g_type g10_in, g10_ff;
   logic [62:0] mnx_ff, mny_ff;
   logic [31:0] len_ff;

   assign f_out = line_f_ff[sfa_pkg::SQRT_STAGES-1];

   always_comb begin
      g10_in.valid = f_out.valid;
      g10_in.zero  = f_out.zero;
      g10_in.clamp = f_out.clamp;
      g10_in.sfx   = f_out.sfx;
      g10_in.sfy   = f_out.sfy;
      g10_in.fx    = f_out.fx;
      g10_in.fy    = f_out.fy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g10_ff <= '0;
      end else if (en) begin
         g10_ff <= g10_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mnx_ff <= {32'b0, f_out.ax} * {32'b0, max_force_ff};
         mny_ff <= {32'b0, f_out.ay} * {32'b0, max_force_ff};
         len_ff <= len;
      end
   end

   logic [30:0] limx, limy;
   sfa_pkg::side_g_type line_g_ff [sfa_pkg::DIV_STAGES];

   sfa_div u_div_limx (
      .clock (clock),
      .en    (en),
      .num   (mnx_ff),
      .den   (len_ff),
      .quo   (limx)
   );

   sfa_div u_div_limy (
      .clock (clock),
      .en    (en),
      .num   (mny_ff),
      .den   (len_ff),
      .quo   (limy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfa_pkg::DIV_STAGES; i++) line_g_ff[i] <= '0;
      end else if (en) begin
         line_g_ff[0] <= g10_ff;
         for (int i = 1; i < sfa_pkg::DIV_STAGES; i++) line_g_ff[i] <= line_g_ff[i-1];
      end
   end

   // ---------------- output register ----------------
   sfa_pkg::side_g_type g_out;
   logic               rsp_valid_ff;
   logic signed [31:0] force_x_ff, force_y_ff;
   logic signed [31:0] force_x_in, force_y_in;

   assign g_out = line_g_ff[sfa_pkg::DIV_STAGES-1];

   always_comb begin
      if (g_out.zero) begin
         force_x_in = '0;
         force_y_in = '0;
      end else if (g_out.clamp) begin
         force_x_in = g_out.sfx ? -$signed({1'b0, limx}) : $signed({1'b0, limx});
         force_y_in = g_out.sfy ? -$signed({1'b0, limy}) : $signed({1'b0, limy});
      end else begin
         force_x_in = g_out.fx;
         force_y_in = g_out.fy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= g_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         force_x_ff <= force_x_in;
         force_y_ff <= force_y_in;
      end
   end

   // Advance the whole pipeline unless the output holds an untaken result
   assign en = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready   = en;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.force_x = force_x_ff;
   assign rsp_bus.force_y = force_y_ff;

endmodule

### src/sfa_sqrt.sv
module sfa_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   logic [63:0] rem_ff  [sfa_pkg::SQRT_STAGES];
   logic [31:0] root_ff [sfa_pkg::SQRT_STAGES];

   for (genvar s = 0; s < sfa_pkg::SQRT_STAGES; s++) begin : g_stage
      localparam int K = sfa_pkg::SQRT_STAGES - 1 - s;
      logic [63:0] rem_prev;
      logic [31:0] root_prev;
      logic [65:0] trial;
      logic [63:0] rem_in;
      logic [31:0] root_in;

      if (s == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 4^k
      always_comb begin
         trial = ({34'b0, root_prev} << (K + 1)) + (66'd1 << (2 * K));
         if ({2'b0, rem_prev} >= trial) begin
            rem_in  = rem_prev - trial[63:0];
            root_in = root_prev | (32'd1 << K);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign root = root_ff[sfa_pkg::SQRT_STAGES-1];

endmodule

### src/sfa_div.sv
module sfa_div (
   input  logic        clock,
   input  logic        en,
   input  logic [62:0] num,
   input  logic [31:0] den,
   output logic [30:0] quo
);

   logic [62:0] rem_ff [sfa_pkg::DIV_STAGES];
   logic [31:0] den_ff [sfa_pkg::DIV_STAGES];
   logic [30:0] quo_ff [sfa_pkg::DIV_STAGES];

   // Quotient is known to fit in 31 bits: restore one bit per stage, MSB first
   for (genvar s = 0; s < sfa_pkg::DIV_STAGES; s++) begin : g_stage
      localparam int K = sfa_pkg::DIV_STAGES - 1 - s;
      logic [62:0] rem_prev;
      logic [31:0] den_prev;
      logic [30:0] quo_prev;
      logic [63:0] shifted;
      logic [62:0] rem_in;
      logic [30:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      always_comb begin
         shifted = {32'b0, den_prev} << K;
         if ({1'b0, rem_prev} >= shifted) begin
            rem_in = rem_prev - shifted[62:0];
            quo_in = quo_prev | (31'd1 << K);
         end else begin
            rem_in = rem_prev;
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[sfa_pkg::DIV_STAGES-1];

endmodule

### dv/steering_force_seek_flee_arrive_unit_tb.sv
`timescale 1ns / 100ps

module testbench;

   typedef struct {
      logic [1:0]         func;
      logic signed [31:0] px, py, vx, vy, tx, ty;
   } steer_req_type;

   typedef struct {
      logic signed [31:0] fx, fy;
   } steer_force_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = sfa_pkg::CSR_MAX_SPEED;
   logic [30:0] csr_wdata = '0;

   sfa_req_if req_bus ();
   sfa_rsp_if rsp_bus ();

   steering_force_seek_flee_arrive_unit dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   longint unsigned speed_cfg = 65536, force_cfg = 65536, radius_cfg = 131072;
   steer_force_type pending_forces[$];
   int              error_count = 0;
   int              force_count = 0;
   int              sent_count = 0;
   bit              quiet_sides = 1'b0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func = sfa_pkg::FUNC_SEEK;
      req_bus.pos_x = '0; req_bus.pos_y = '0;
      req_bus.vel_x = '0; req_bus.vel_y = '0;
      req_bus.target_x = '0; req_bus.target_y = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic longint sat_32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned abs_64(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint scale_by(longint v, longint unsigned num,
                                       longint unsigned den);
      longint unsigned m;
      m = abs_64(v) * num / den;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic steer_force_type predict_force(steer_req_type r);
      steer_force_type f;
      longint          dx, dy, desx, desy, fx, fy, rx, ry;
      longint unsigned ux, uy, span, ax, ay, spd, len;
      bit              clamp;
      f.fx = 0; f.fy = 0;
      desx = 0; desy = 0;
      if (r.func == sfa_pkg::FUNC_NONE) return f;
      if (r.func == sfa_pkg::FUNC_FLEE) begin
         dx = sat_32(longint'(r.px) - r.tx);
         dy = sat_32(longint'(r.py) - r.ty);
      end else begin
         dx = sat_32(longint'(r.tx) - r.px);
         dy = sat_32(longint'(r.ty) - r.py);
      end
      ux = abs_64(dx); uy = abs_64(dy);
      span = int_sqrt(ux * ux + uy * uy);
      if (span < sfa_pkg::NEAR_LIMIT) begin
         if (r.func == sfa_pkg::FUNC_FLEE) return f;
      end else begin
         spd = speed_cfg;
         if (r.func == sfa_pkg::FUNC_ARRIVE && span < radius_cfg)
            spd = speed_cfg * span / radius_cfg;
         desx = scale_by(dx, spd, span);
         desy = scale_by(dy, spd, span);
      end
      fx = desx - r.vx; fy = desy - r.vy;
      ax = abs_64(fx); ay = abs_64(fy);
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
         ax >>= 1; ay >>= 1;
         clamp = 1'b1;
      end else begin
         clamp = ax * ax + ay * ay > force_cfg * force_cfg;
      end
      if (clamp) begin
         len = int_sqrt(ax * ax + ay * ay);
         rx = longint'(ax * force_cfg / len);
         ry = longint'(ay * force_cfg / len);
         if (fx < 0) rx = -rx;
         if (fy < 0) ry = -ry;
      end else begin
         rx = fx; ry = fy;
      end
      f.fx = 32'(sat_32(rx));
      f.fy = 32'(sat_32(ry));
      return f;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic send_request(steer_req_type r);
      while (!quiet_sides && $urandom_range(99) < 18) @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.func = r.func;
      req_bus.pos_x = r.px; req_bus.pos_y = r.py;
      req_bus.vel_x = r.vx; req_bus.vel_y = r.vy;
      req_bus.target_x = r.tx; req_bus.target_y = r.ty;
      pending_forces.push_back(predict_force(r));
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // ready toggles on the falling edge; results are taken on the rising edge
   always @(negedge clock) rsp_bus.ready <= quiet_sides || ($urandom_range(99) >= 18);

   always @(posedge clock) begin
      steer_force_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         force_count++;
         if (pending_forces.size() == 0) begin
            report_mismatch("force with no request outstanding");
         end else begin
            want = pending_forces.pop_front();
            if (rsp_bus.force_x !== want.fx)
               report_mismatch($sformatf("force_x %h want %h", rsp_bus.force_x, want.fx));
            if (rsp_bus.force_y !== want.fy)
               report_mismatch($sformatf("force_y %h want %h", rsp_bus.force_y, want.fy));
         end
      end
   end

   task automatic drain_and_write(logic [1:0] idx, logic [30:0] val);
      while (pending_forces.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         sfa_pkg::CSR_MAX_SPEED:   speed_cfg = val;
         sfa_pkg::CSR_MAX_FORCE:   force_cfg = val;
         sfa_pkg::CSR_SLOW_RADIUS: radius_cfg = val;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return 32'($signed($urandom_range(8192)) - 4096);
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   function automatic steer_req_type rand_request();
      steer_req_type r;
      r.func = ($urandom_range(19) == 0) ? sfa_pkg::FUNC_NONE : 2'($urandom_range(2));
      r.px = rand_coord(); r.py = rand_coord();
      r.vx = rand_coord(); r.vy = rand_coord();
      if ($urandom_range(9) == 0) begin
         r.tx = r.px; r.ty = r.py;
      end else if ($urandom_range(3) == 0) begin
         r.tx = r.px + 32'($signed($urandom_range(600000)) - 300000);
         r.ty = r.py + 32'($signed($urandom_range(600000)) - 300000);
      end else begin
         r.tx = rand_coord(); r.ty = rand_coord();
      end
      return r;
   endfunction

   task automatic test_directed();
      steer_req_type r;
      logic [31:0] ext[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      for (int m = 0; m < 4; m++) begin
         // zero distance
         r = '{2'(m), 100, -200, 3000, -70000, 100, -200};
         send_request(r);
         r = '{2'(m), 0, 0, 0, 0, 65536, 0};
         send_request(r);
      end
      for (int i = 0; i < 4; i++) begin
         r = '{sfa_pkg::FUNC_SEEK, ext[i], ext[3-i], ext[i], ext[i], ext[3-i], ext[i]};
         send_request(r);
         r = '{sfa_pkg::FUNC_FLEE, ext[3-i], ext[i], ext[3-i], ext[i], ext[i], ext[3-i]};
         send_request(r);
         r = '{sfa_pkg::FUNC_ARRIVE, ext[i], ext[i], ext[3-i], ext[3-i], ext[3-i], ext[3-i]};
         send_request(r);
      end
      // arrive inside and outside the slow radius, small force needing no clamp
      r = '{sfa_pkg::FUNC_ARRIVE, 0, 0, 0, 0, 65536, 0}; send_request(r);
      r = '{sfa_pkg::FUNC_ARRIVE, 0, 0, 0, 0, 300000, 0}; send_request(r);
      r = '{sfa_pkg::FUNC_SEEK, 0, 0, 60000, 0, 65536, 0}; send_request(r);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         quiet_sides = (i >= count / 3) && (i < count / 3 + 80);
         send_request(rand_request());
      end
      quiet_sides = 1'b0;
   endtask

   task automatic test_settings();
      logic [30:0] vals[6] = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd65536, 31'd3000000, 31'd200};
      for (int s = 0; s < 6; s++) begin
         drain_and_write(sfa_pkg::CSR_MAX_SPEED, vals[s]);
         drain_and_write(sfa_pkg::CSR_MAX_FORCE, vals[(s + 2) % 6]);
         drain_and_write(sfa_pkg::CSR_SLOW_RADIUS, vals[(s + 4) % 6]);
         test_random(110);
      end
      drain_and_write(sfa_pkg::CSR_MAX_SPEED, 31'($urandom));
      drain_and_write(sfa_pkg::CSR_MAX_FORCE, 31'($urandom));
      drain_and_write(sfa_pkg::CSR_SLOW_RADIUS, 31'($urandom));
      test_random(110);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(130);
      test_settings();
      while (pending_forces.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("sent %0d requests over seek, flee, arrive and unused mode; checked %0d forces",
               sent_count, force_count);
      $display("covered reset values plus seven register settings including both extremes");
      if (error_count == 0 && pending_forces.size() == 0) begin
         $display("steering_force_seek_flee_arrive_unit regression: pass");
      end else begin
         $display("steering_force_seek_flee_arrive_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("steering_force_seek_flee_arrive_unit regression: fail");
      $finish;
   end
endmodule
